// ----- sv/i2cm_pkg.sv -----
// Shared types, codes and helpers for the I2C master bit engine.
`default_nettype none
package i2cm_pkg;

  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_RESTART = 3'd1;
  localparam logic [2:0] OP_STOP    = 3'd2;
  localparam logic [2:0] OP_WRITE   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_ACK     = 3'd5;
  localparam logic [2:0] OP_NACK    = 3'd6;
  localparam logic [2:0] OP_IDLE    = 3'd7;

  localparam logic [7:0] DIVIDER_RESET = 8'h09;
  localparam logic [3:0] ACK_SLOT      = 4'd8;
  localparam logic [1:0] Q_SAMPLE      = 2'd1;

  typedef struct packed {
    logic       command_valid;
    logic [2:0] command;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic       no_ack_seen;
    logic [7:0] read_byte;
  } out_item_t;

  // Classified tick held between front and back.
  typedef struct packed {
    logic       go;
    logic [2:0] op;
    logic [7:0] data;
    logic       sda;
  } tick_t;

  function automatic logic [3:0] slot_count(input logic [2:0] op);
    logic [3:0] n;
    case (op)
      OP_WRITE: n = 4'd9;
      OP_READ:  n = 4'd8;
      default:  n = 4'd1;
    endcase
    return n;
  endfunction

  // Bit 0 drives SCL low, bit 1 drives SDA low.
  function automatic logic [1:0] quarter_drive(input logic [2:0] op, input logic [3:0] slot,
                                               input logic [1:0] q, input logic [7:0] sb);
    logic scl;
    logic sda;
    scl = 1'b0;
    sda = 1'b0;
    case (op)
      OP_START: scl = (q == 2'd3);
      OP_STOP:  scl = (q == 2'd0);
      default:  scl = (q == 2'd0) || (q == 2'd3);
    endcase
    case (op)
      OP_START, OP_RESTART: sda = (q >= 2'd2);
      OP_STOP:              sda = (q <= 2'd1);
      OP_WRITE:             sda = (slot < ACK_SLOT) ? ~sb[3'd7 - slot[2:0]] : 1'b0;
      OP_ACK:               sda = 1'b1;
      default:              sda = 1'b0;
    endcase
    return {sda, scl};
  endfunction

endpackage
`default_nettype wire

// ----- sv/i2cm_fifo.sv -----
// Small first-in first-out queue of packed words.
`default_nettype none
module i2cm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_push_full: assert property (@(posedge clk) disable iff (rst)
      full && !do_pop |=> full)
    else $error("full queue lost an entry without a pop");
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
      empty && !do_push |=> empty)
    else $error("empty queue gained an entry without a push");
endmodule
`default_nettype wire

// ----- sv/i2cm_front.sv -----
// Front end: accept input ticks, classify the command and queue them.
`default_nettype none
module i2cm_front import i2cm_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t in_item,
  output logic     full,
  output logic     tick_valid,
  output tick_t    tick,
  input  logic     tick_take
);
  tick_t cls;
  logic  q_empty;

  // Code 7 carries no command; drop the valid flag here.
  always_comb begin
    cls.go   = in_item.command_valid && (in_item.command != OP_IDLE);
    cls.op   = in_item.command;
    cls.data = in_item.write_data;
    cls.sda  = in_item.sda_in;
  end

  i2cm_fifo #(.WIDTH($bits(tick_t)), .DEPTH(DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (tick_take),
    .rdata (tick),
    .empty (q_empty)
  );

  assign tick_valid = !q_empty;
endmodule
`default_nettype wire

// ----- sv/i2cm_engine.sv -----
// Back end: bit engine that advances one tick per queued item.
`default_nettype none
module i2cm_engine import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] divider,
  input  logic       tick_valid,
  input  tick_t      tick,
  output logic       tick_take,
  input  logic       res_ready,
  output logic       res_push,
  output out_item_t  res_item
);
  logic [7:0] tick_count, tick_count_next;
  logic [1:0] quarter, quarter_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] active_op, active_op_next;
  logic       ack_status, ack_status_next;
  logic [1:0] line_drive, line_drive_next;
  logic [7:0] last_read, last_read_next;
  logic       done;

  assign tick_take = tick_valid && res_ready;
  assign res_push  = tick_take;

  always_comb begin
    tick_count_next = tick_count;
    quarter_next    = quarter;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    active_op_next  = active_op;
    ack_status_next = ack_status;
    line_drive_next = line_drive;
    last_read_next  = last_read;
    done            = 1'b0;
    if (active_op == OP_IDLE) begin
      if (tick.go) begin
        active_op_next  = tick.op;
        tick_count_next = '0;
        quarter_next    = '0;
        bit_index_next  = '0;
        shift_byte_next = (tick.op == OP_READ) ? '0 : tick.data;
        line_drive_next = quarter_drive(tick.op, 4'd0, 2'd0, shift_byte_next);
      end
    end else if (tick_count >= divider) begin
      tick_count_next = '0;
      if (quarter == Q_SAMPLE) begin
        if (active_op == OP_WRITE && bit_index == ACK_SLOT) begin
          ack_status_next = tick.sda;
        end else if (active_op == OP_READ) begin
          shift_byte_next = {shift_byte[6:0], tick.sda};
        end
      end
      quarter_next = quarter + 1'b1;
      if (quarter_next == 2'd0) begin
        bit_index_next = bit_index + 1'b1;
      end
      if (bit_index_next >= slot_count(active_op)) begin
        if (active_op == OP_READ) begin
          last_read_next = shift_byte_next;
        end
        active_op_next = OP_IDLE;
        bit_index_next = '0;
        done           = 1'b1;
      end else begin
        line_drive_next = quarter_drive(active_op, bit_index_next, quarter_next,
                                        shift_byte_next);
      end
    end else begin
      tick_count_next = tick_count + 1'b1;
    end
  end

  always_comb begin
    res_item.scl_low     = line_drive_next[0];
    res_item.sda_low     = line_drive_next[1];
    res_item.busy_res    = (active_op_next != OP_IDLE);
    res_item.done_res    = done;
    res_item.no_ack_seen = ack_status_next;
    res_item.read_byte   = last_read_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      quarter    <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
      active_op  <= OP_IDLE;
      ack_status <= 1'b0;
      line_drive <= '0;
      last_read  <= '0;
    end else if (tick_take) begin
      tick_count <= tick_count_next;
      quarter    <= quarter_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      active_op  <= active_op_next;
      ack_status <= ack_status_next;
      line_drive <= line_drive_next;
      last_read  <= last_read_next;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
      res_push && res_item.done_res |-> !res_item.busy_res)
    else $error("done reported while still busy");
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
      active_op == OP_IDLE |-> bit_index == 4'd0 && tick_count == 8'd0)
    else $error("idle engine holds stale slot or tick count");
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
      active_op != OP_IDLE |-> bit_index < slot_count(active_op))
    else $error("slot index past end of command");
  a_hold: assert property (@(posedge clk) disable iff (rst)
      !tick_take |=> $stable(active_op) && $stable(line_drive))
    else $error("engine state moved without a tick");
endmodule
`default_nettype wire

// ----- sv/i2c_master_byte_engine.sv -----
// I2C master bit engine: top level with input queue, engine and result queue.
//
// Each input transaction is one tick of the bit engine: a command flag, a
// command code, a write byte and the sampled SDA level. Push it while full is
// low. Each tick yields exactly one result transaction: SCL/SDA pull-down
// drive, busy, a done pulse, the ACK status of the last write and the last
// read byte. A result is waiting while empty is low and is taken with pop.
// A tick flows through the front queue, the engine and the result queue: the
// engine takes the tick at the head of the front queue and pushes its result
// into the result queue in the same cycle; from there it reaches the result
// ports and is taken with pop. Throughput is one tick per cycle while the
// result queue has room, set by the engine that updates its state once per
// taken tick. When the receiver stops popping the result queue fills, the
// engine holds, and full rises once the front queue is full too; no tick or
// result is dropped. The clock divider is written through cfg_we and cfg_wdata
// and acts on the next tick the engine runs. Reset empties both queues, puts
// the engine idle with both lines released, and loads the divider with 9.
`default_nettype none
module i2c_master_byte_engine import i2cm_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  in_item_t   in_item,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  logic       divider_low;
  logic [7:0] divider;
  logic       tick_valid;
  tick_t      tick;
  logic       tick_take;
  logic       res_push;
  out_item_t  res_item;
  logic       res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      divider <= DIVIDER_RESET;
    end else if (cfg_we) begin
      divider <= cfg_wdata;
    end
  end

  assign divider_low = (divider == 8'd0);

  i2cm_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .in_item    (in_item),
    .full       (full),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_take  (tick_take)
  );

  i2cm_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .divider    (divider),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_take  (tick_take),
    .res_ready  (!res_full),
    .res_push   (res_push),
    .res_item   (res_item)
  );

  i2cm_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(QUEUE_DEPTH)) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_item),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_item),
    .empty (empty)
  );

  // With a zero divider every busy tick ends a quarter.
  a_fast_quarter: assert property (@(posedge clk) disable iff (rst)
      divider_low && tick_take && res_item.busy_res && !$past(cfg_we) |->
      u_engine.tick_count_next == 8'd0)
    else $error("quarter did not advance with zero divider");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
      tick_take == res_push)
    else $error("tick taken without a result");
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
      res_push |-> !res_full)
    else $error("result pushed into a full queue");
endmodule
`default_nettype wire
